// ===== hdl/kht_pkg.sv =====
// Shared types, codes and defaults for the keyed hash table engine.
`default_nettype none
package kht_pkg;
  localparam int REQ_W = 3;
  localparam int KEY_W = 32;
  localparam int ID_PORT_W = 11;
  localparam int STATUS_W = 2;

  localparam int DEF_ENTRIES = 1024;
  localparam int DEF_NUM_BUCKETS = 8192;
  localparam int DEF_KEY_BYTES = 4;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef logic [REQ_W-1:0] req_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam req_t REQ_CREATE_KEYED = 3'd0;
  localparam req_t REQ_CREATE_UNKEYED = 3'd1;
  localparam req_t REQ_DELETE_ID = 3'd2;
  localparam req_t REQ_QUERY_KEY = 3'd3;
  localparam req_t REQ_QUERY_ID = 3'd4;

  localparam status_t STAT_OK = 2'd0;
  localparam status_t STAT_NOT_FOUND = 2'd1;
  localparam status_t STAT_FULL = 2'd2;
  localparam status_t STAT_BAD_ID = 2'd3;

  localparam logic [1:0] FLAG_NONE = 2'b00;
  localparam logic [1:0] FLAG_LIVE = 2'b01;
  localparam logic [1:0] FLAG_LIVE_KEYED = 2'b11;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_FREE_WT, S_FLAG_WT, S_DEL_WT, S_HINIT, S_HASH,
    S_MOD, S_HEAD_RD, S_HEAD_WT, S_LINK, S_WALK_RD, S_WALK_WT, S_DEL_FIX, S_RESP
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LATCH, OP_FREE_RD, OP_FLAG_RD, OP_ALLOC, OP_CHECK,
    OP_DEL_LOAD, OP_HASH_INIT, OP_HASH, OP_MOD, OP_HEAD_RD, OP_HEAD_WR, OP_LINK,
    OP_WALK_START, OP_WALK_RD, OP_WALK_CMP, OP_DEL_FIX, OP_RESP
  } dp_op_t;

  typedef enum logic [1:0] {EID_ZERO, EID_NEW, EID_TARGET, EID_CUR} eid_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     ready;
    status_t  code;
    eid_sel_t eid;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic clear_done;
    req_t req;
    logic free_empty;
    logic tid_ok;
    logic live;
    logic keyed;
    logic hash_last;
    logic mod_last;
    logic mod_needed;
    logic walk_ok;
    logic match;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

// ===== hdl/kht_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
`default_nettype none
interface kht_req_if;
  logic valid;
  logic ready;
  logic [kht_pkg::REQ_W-1:0] req_type;
  logic [kht_pkg::KEY_W-1:0] lookup_key;
  logic [kht_pkg::ID_PORT_W-1:0] target_id;

  modport source(output valid, output req_type, output lookup_key, output target_id,
                 input ready);
  modport sink(input valid, input req_type, input lookup_key, input target_id,
               output ready);
endinterface
`default_nettype wire

// ===== hdl/kht_rsp_if.sv =====
// Response channel: valid/ready handshake with the result fields.
`default_nettype none
interface kht_rsp_if;
  logic valid;
  logic ready;
  logic [kht_pkg::STATUS_W-1:0] status;
  logic [kht_pkg::ID_PORT_W-1:0] entry_id;
  logic [kht_pkg::ID_PORT_W-1:0] live_count;

  modport source(output valid, output status, output entry_id, output live_count,
                 input ready);
  modport sink(input valid, input status, input entry_id, input live_count,
               output ready);
endinterface
`default_nettype wire

// ===== hdl/kht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/kht_ctrl.sv =====
// Request sequencer: decode, hash and chain if needed, then response per item.
`default_nettype none
module kht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire kht_pkg::stat_t stat,
  output kht_pkg::cmd_t      cmd
);
  import kht_pkg::*;

  state_t   state, state_next;
  status_t  resp_code, resp_code_next;
  eid_sel_t resp_eid, resp_eid_next;
  state_t   after_hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      resp_code <= STAT_OK;
      resp_eid <= EID_ZERO;
    end else begin
      state <= state_next;
      resp_code <= resp_code_next;
      resp_eid <= resp_eid_next;
    end
  end

  always_comb begin
    state_next = state;
    resp_code_next = resp_code;
    resp_eid_next = resp_eid;
    cmd.op = OP_NONE;
    cmd.ready = 1'b0;
    cmd.code = resp_code;
    cmd.eid = resp_eid;
    after_hash = (stat.req == REQ_DELETE_ID) ? S_DEL_FIX : S_HEAD_RD;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (stat.in_valid) begin
          cmd.op = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.req == REQ_CREATE_KEYED || stat.req == REQ_CREATE_UNKEYED) begin
          if (stat.free_empty) begin
            resp_code_next = STAT_FULL;
            resp_eid_next = EID_ZERO;
            state_next = S_RESP;
          end else begin
            cmd.op = OP_FREE_RD;
            state_next = S_FREE_WT;
          end
        end else if (stat.req == REQ_DELETE_ID || stat.req == REQ_QUERY_ID) begin
          if (!stat.tid_ok) begin
            resp_code_next = STAT_BAD_ID;
            resp_eid_next = EID_ZERO;
            state_next = S_RESP;
          end else begin
            cmd.op = OP_FLAG_RD;
            state_next = S_FLAG_WT;
          end
        end else if (stat.req == REQ_QUERY_KEY) begin
          state_next = S_HINIT;
        end else begin
          resp_code_next = STAT_OK;
          resp_eid_next = EID_ZERO;
          state_next = S_RESP;
        end
      end
      S_FREE_WT: begin
        cmd.op = OP_ALLOC;
        if (stat.req == REQ_CREATE_UNKEYED) begin
          resp_code_next = STAT_OK;
          resp_eid_next = EID_NEW;
          state_next = S_RESP;
        end else begin
          state_next = S_HINIT;
        end
      end
      S_FLAG_WT: begin
        cmd.op = OP_CHECK;
        priority if (!stat.live) begin
          resp_code_next = STAT_BAD_ID;
          resp_eid_next = EID_ZERO;
          state_next = S_RESP;
        end else if (stat.req == REQ_QUERY_ID) begin
          resp_code_next = STAT_OK;
          resp_eid_next = EID_TARGET;
          state_next = S_RESP;
        end else if (stat.keyed) begin
          state_next = S_DEL_WT;
        end else begin
          resp_code_next = STAT_OK;
          resp_eid_next = EID_ZERO;
          state_next = S_RESP;
        end
      end
      S_DEL_WT: begin
        cmd.op = OP_DEL_LOAD;
        state_next = S_HINIT;
      end
      S_HINIT: begin
        cmd.op = OP_HASH_INIT;
        state_next = S_HASH;
      end
      S_HASH: begin
        cmd.op = OP_HASH;
        if (stat.hash_last) state_next = stat.mod_needed ? S_MOD : after_hash;
      end
      S_MOD: begin
        cmd.op = OP_MOD;
        if (stat.mod_last) state_next = after_hash;
      end
      S_HEAD_RD: begin
        cmd.op = OP_HEAD_RD;
        state_next = S_HEAD_WT;
      end
      S_HEAD_WT: begin
        if (stat.req == REQ_CREATE_KEYED) begin
          cmd.op = OP_HEAD_WR;
          state_next = S_LINK;
        end else begin
          cmd.op = OP_WALK_START;
          state_next = S_WALK_RD;
        end
      end
      S_LINK: begin
        cmd.op = OP_LINK;
        resp_code_next = STAT_OK;
        resp_eid_next = EID_NEW;
        state_next = S_RESP;
      end
      S_WALK_RD: begin
        if (stat.walk_ok) begin
          cmd.op = OP_WALK_RD;
          state_next = S_WALK_WT;
        end else begin
          resp_code_next = STAT_NOT_FOUND;
          resp_eid_next = EID_ZERO;
          state_next = S_RESP;
        end
      end
      S_WALK_WT: begin
        cmd.op = OP_WALK_CMP;
        if (stat.match) begin
          resp_code_next = STAT_OK;
          resp_eid_next = EID_CUR;
          state_next = S_RESP;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_DEL_FIX: begin
        cmd.op = OP_DEL_FIX;
        resp_code_next = STAT_OK;
        resp_eid_next = EID_ZERO;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.op = OP_RESP;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/kht_dp.sv =====
// Datapath: entry stores, bucket heads, free list, hash unit and result register.
`default_nettype none
module kht_dp #(
  parameter int ENTRIES = kht_pkg::DEF_ENTRIES,
  parameter int NUM_BUCKETS = kht_pkg::DEF_NUM_BUCKETS,
  parameter int KEY_BYTES = kht_pkg::DEF_KEY_BYTES
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire kht_pkg::cmd_t  cmd,
  output kht_pkg::stat_t      stat,
  kht_req_if.sink             req,
  kht_rsp_if.source           rsp
);
  import kht_pkg::*;

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int ID_W = $clog2(ENTRIES + 1);
  localparam int BKT_W = $clog2(NUM_BUCKETS);
  localparam int KW = 8 * KEY_BYTES;
  localparam int CLR_N = (ENTRIES > NUM_BUCKETS) ? ENTRIES : NUM_BUCKETS;
  localparam int CLR_W = $clog2(CLR_N);
  localparam bit BKT_POW2 = ((1 << BKT_W) == NUM_BUCKETS);
  localparam logic [31:0] KEY_MASK =
    (KW >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << KW) - 64'd1);
  localparam int RECIP_SH = 32 + BKT_W;
  localparam logic [63:0] RECIP = (64'd1 << RECIP_SH) / 64'(NUM_BUCKETS);
  localparam logic [31:0] RECIP_LO = RECIP[31:0];

  req_t              req_r;
  logic [KEY_W-1:0]  key_r;
  logic [ID_PORT_W-1:0] tid_r;
  logic [ID_W-1:0]   id_r, hreg, p_r, n_r, cur, steps;
  logic [31:0]       h;
  logic [BKT_W-1:0]  rem;
  logic [KW-1:0]     kreg;
  logic [4:0]        cnt;
  logic [SLOT_W-1:0] rptr, wptr;
  logic [ID_W-1:0]   free_count, used_count;
  logic [CLR_W-1:0]  clr_idx;
  logic              out_valid;
  status_t           out_status;
  logic [ID_PORT_W-1:0] out_eid, out_live;
  logic [63:0]       mprod;
  logic [31:0]       q_est;
  logic [BKT_W:0]    mod_r;

  logic [KW+KEY_W-1:0] kx;
  logic [64:0]       msum;
  logic [BKT_W-1:0]  rem_next, bucket;
  logic [31:0]       h_next;
  logic [ID_W-1:0]   tid_id, id_fix, eid_val;
  logic              release_now;

  logic              fl_we, fi_we, ks_we, cn_we, cp_we, bh_we;
  logic [SLOT_W-1:0] fl_wa, fl_ra, fi_wa, ks_wa, ks_ra, cn_wa, cp_wa;
  logic [BKT_W-1:0]  bh_wa;
  logic [1:0]        fl_wd, fl_rd;
  logic [ID_W-1:0]   fi_wd, fi_rd, cn_wd, cn_rd, cp_wd, cp_rd, bh_wd, bh_rd;
  logic [KEY_W-1:0]  ks_wd, ks_rd;

  function automatic logic id_valid(input logic [ID_W-1:0] x);
    return (x != '0) && (x <= ID_W'(ENTRIES));
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_W-1:0] x);
    return SLOT_W'(x - 1'b1);
  endfunction

  assign kx = {{KW{1'b0}}, key_r};
  assign tid_id = ID_W'(tid_r);
  assign id_fix = id_valid(fi_rd) ? fi_rd : ID_W'(1);
  assign h_next = (h << 5) + h + 32'(kreg[KW-1 -: 8]);
  assign msum = {1'b0, h, 32'd0} + {1'b0, mprod};
  assign rem_next = (mod_r >= (BKT_W+1)'(NUM_BUCKETS)) ?
                    BKT_W'(mod_r - (BKT_W+1)'(NUM_BUCKETS)) : BKT_W'(mod_r);
  assign bucket = BKT_POW2 ? h[BKT_W-1:0] : rem;
  assign release_now = (cmd.op == OP_DEL_FIX) ||
                       (cmd.op == OP_CHECK && req_r == REQ_DELETE_ID &&
                        fl_rd == FLAG_LIVE);

  always_comb begin
    unique case (cmd.eid)
      EID_NEW:    eid_val = id_r;
      EID_TARGET: eid_val = tid_id;
      EID_CUR:    eid_val = cur;
      default:    eid_val = '0;
    endcase
  end

  always_comb begin
    stat.in_valid = req.valid;
    stat.clear_done = (32'(clr_idx) == CLR_N - 1);
    stat.req = req_r;
    stat.free_empty = (free_count == '0);
    stat.tid_ok = (tid_r != '0) && (32'(tid_r) <= ENTRIES);
    stat.live = fl_rd[0];
    stat.keyed = fl_rd[1];
    stat.hash_last = (cnt == 5'(KEY_BYTES - 1));
    stat.mod_last = (cnt == 5'd3);
    stat.mod_needed = !BKT_POW2;
    stat.walk_ok = id_valid(cur) && (steps < ID_W'(ENTRIES));
    stat.match = (fl_rd == FLAG_LIVE_KEYED) && (ks_rd == key_r);
    stat.out_busy = out_valid && !rsp.ready;
  end

  always_comb begin
    fl_we = 1'b0; fl_wa = '0; fl_wd = FLAG_NONE; fl_ra = slot_of(cur);
    fi_we = 1'b0; fi_wa = wptr; fi_wd = tid_id;
    ks_we = 1'b0; ks_wa = slot_of(id_r); ks_wd = key_r; ks_ra = slot_of(cur);
    cn_we = 1'b0; cn_wa = slot_of(id_r); cn_wd = bh_rd;
    cp_we = 1'b0; cp_wa = slot_of(id_r); cp_wd = '0;
    bh_we = 1'b0; bh_wa = bucket; bh_wd = id_r;
    unique case (cmd.op)
      OP_CLEAR: begin
        fl_we = (32'(clr_idx) < ENTRIES);
        fl_wa = SLOT_W'(clr_idx);
        fi_we = (32'(clr_idx) < ENTRIES);
        fi_wa = SLOT_W'(clr_idx);
        fi_wd = ID_W'(clr_idx) + 1'b1;
        bh_we = (32'(clr_idx) < NUM_BUCKETS);
        bh_wa = BKT_W'(clr_idx);
        bh_wd = '0;
      end
      OP_FLAG_RD: fl_ra = slot_of(tid_id);
      OP_ALLOC: begin
        fl_we = 1'b1;
        fl_wa = slot_of(id_fix);
        fl_wd = (req_r == REQ_CREATE_KEYED) ? FLAG_LIVE_KEYED : FLAG_LIVE;
      end
      OP_CHECK: begin
        ks_ra = slot_of(tid_id);
        fl_we = release_now;
        fl_wa = slot_of(tid_id);
        fi_we = release_now;
      end
      OP_HEAD_WR: begin
        ks_we = 1'b1;
        cn_we = 1'b1;
        cp_we = 1'b1;
        bh_we = 1'b1;
      end
      OP_LINK: begin
        cp_we = id_valid(hreg);
        cp_wa = slot_of(hreg);
        cp_wd = id_r;
      end
      OP_DEL_FIX: begin
        cn_we = id_valid(p_r);
        cn_wa = slot_of(p_r);
        cn_wd = n_r;
        bh_we = !id_valid(p_r);
        bh_wd = n_r;
        cp_we = id_valid(n_r);
        cp_wa = slot_of(n_r);
        cp_wd = p_r;
        fl_we = 1'b1;
        fl_wa = slot_of(tid_id);
        fi_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      rptr <= '0;
      wptr <= '0;
      free_count <= ID_W'(ENTRIES);
      used_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (cmd.op == OP_ALLOC) begin
        rptr <= (rptr == SLOT_W'(ENTRIES - 1)) ? '0 : rptr + 1'b1;
        free_count <= free_count - 1'b1;
        used_count <= used_count + 1'b1;
      end
      if (release_now) begin
        wptr <= (wptr == SLOT_W'(ENTRIES - 1)) ? '0 : wptr + 1'b1;
        free_count <= free_count + 1'b1;
        used_count <= used_count - 1'b1;
      end
      if (cmd.op == OP_RESP) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        req_r <= req.req_type;
        key_r <= req.lookup_key & KEY_MASK;
        tid_r <= req.target_id;
      end
      OP_ALLOC: id_r <= id_fix;
      OP_DEL_LOAD: begin
        key_r <= ks_rd;
        p_r <= cp_rd;
        n_r <= cn_rd;
      end
      OP_HASH_INIT: begin
        h <= HASH_SEED;
        kreg <= kx[KW-1:0];
        cnt <= '0;
        rem <= '0;
      end
      OP_HASH: begin
        h <= h_next;
        kreg <= kreg << 8;
        cnt <= stat.hash_last ? 5'd0 : cnt + 1'b1;
      end
      OP_MOD: begin
        if (cnt == 5'd0) mprod <= 64'(h) * 64'(RECIP_LO);
        if (cnt == 5'd1) q_est <= 32'(msum >> RECIP_SH);
        if (cnt == 5'd2) mod_r <= (BKT_W+1)'(h - q_est * 32'(NUM_BUCKETS));
        if (cnt == 5'd3) rem <= rem_next;
        cnt <= cnt + 1'b1;
      end
      OP_HEAD_WR: hreg <= bh_rd;
      OP_WALK_START: begin
        cur <= bh_rd;
        steps <= '0;
      end
      OP_WALK_CMP: begin
        if (!stat.match) cur <= cn_rd;
        steps <= steps + 1'b1;
      end
      OP_RESP: begin
        out_status <= cmd.code;
        out_eid <= ID_PORT_W'(eid_val);
        out_live <= ID_PORT_W'(used_count);
      end
      default: begin
      end
    endcase
  end

  assign req.ready = cmd.ready;
  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.entry_id = out_eid;
  assign rsp.live_count = out_live;

  kht_ram #(.WIDTH(2), .DEPTH(ENTRIES)) u_flags (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
  kht_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_free (
    .clk(clk), .we(fi_we), .waddr(fi_wa), .wdata(fi_wd), .raddr(rptr), .rdata(fi_rd));
  kht_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_keys (
    .clk(clk), .we(ks_we), .waddr(ks_wa), .wdata(ks_wd), .raddr(ks_ra), .rdata(ks_rd));
  kht_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_next (
    .clk(clk), .we(cn_we), .waddr(cn_wa), .wdata(cn_wd), .raddr(ks_ra), .rdata(cn_rd));
  kht_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_prev (
    .clk(clk), .we(cp_we), .waddr(cp_wa), .wdata(cp_wd), .raddr(ks_ra), .rdata(cp_rd));
  kht_ram #(.WIDTH(ID_W), .DEPTH(NUM_BUCKETS)) u_heads (
    .clk(clk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd), .raddr(bucket), .rdata(bh_rd));

`ifndef SYNTHESIS
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (32'(free_count) + 32'(used_count)) == ENTRIES)
    else $error("free and used counts disagree");
  a_resp_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_RESP |-> !(out_valid && !rsp.ready))
    else $error("result overwritten while held");
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_ALLOC |-> free_count != '0)
    else $error("allocation from empty free list");
  a_resp_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_RESP |=> out_valid)
    else $error("loaded result not presented");
`endif
endmodule
`default_nettype wire

// ===== hdl/keyed_hash_table_engine.sv =====
// Top level of the keyed hash table engine: sequencer plus datapath.
// After reset the block sweeps its flag, free-list and bucket-head memories, one
// address per cycle, across max(ENTRIES, NUM_BUCKETS) addresses (8192 by default)
// before it takes its first item. Then one item is handled at a time: a full table,
// an out-of-range id and an unused request kind go from decode straight to the
// response, and unkeyed creates, id queries, unkeyed deletes and not-live ids first
// read the free list or the flags. Keyed creates, keyed deletes and key queries run
// the hash over the KEY_BYTES key bytes, plus a reciprocal modulo when NUM_BUCKETS is
// not a power of two; a keyed create then links the new entry at its bucket head, a
// keyed delete unlinks the entry, and a key query walks the chain, reading and
// comparing each entry in turn through the single read port of each memory.
// The result register lets the next item enter while a result still waits; the
// sequencer holds in its response state until that register is free.
`default_nettype none
module keyed_hash_table_engine #(
  parameter int ENTRIES = kht_pkg::DEF_ENTRIES,
  parameter int NUM_BUCKETS = kht_pkg::DEF_NUM_BUCKETS,
  parameter int KEY_BYTES = kht_pkg::DEF_KEY_BYTES
) (
  input wire logic  clk,
  input wire logic  rst,
  kht_req_if.sink   req,
  kht_rsp_if.source rsp
);
  import kht_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  kht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .cmd(cmd));

  kht_dp #(.ENTRIES(ENTRIES), .NUM_BUCKETS(NUM_BUCKETS), .KEY_BYTES(KEY_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .req(req), .rsp(rsp));
endmodule
`default_nettype wire
